// ===== rtl/core/rtse_pkg.sv =====
package rtse_pkg;

  localparam int unsigned SET_DEPTH_DEF = 256;
  localparam logic [7:0] DELIM_RST = 8'd124;
  localparam logic [7:0] TERM_RST = 8'd10;
  localparam logic [7:0] SPACE_BYTE = 8'h20;
  localparam logic [15:0] SPACE_PAIR = 16'h2020;
  localparam int unsigned OPS_MAX = 3;

  typedef enum logic [0:0] {
    REG_DELIM = 1'b0,
    REG_TERM = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_OFFER = 2'd0,
    OP_ROWEND = 2'd1,
    OP_CLEAR = 2'd2
  } op_kind_t;

  typedef struct packed {
    op_kind_t kind;
    logic [23:0] tri_val;
    logic last;
  } op_t;

  typedef struct packed {
    logic [31:0] row_number;
    logic [23:0] trigram;
    logic trigram_valid;
    logic row_end;
    logic [8:0] row_trigram_count;
    logic set_overflow;
    logic last_of_input;
  } res_t;

endpackage

// ===== rtl/core/rtse_ifs.sv =====
interface rtse_byte_if;
  logic valid;
  logic ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface rtse_res_if;
  logic valid;
  logic ready;
  logic [31:0] row_number;
  logic [23:0] trigram;
  logic trigram_valid;
  logic row_end;
  logic [8:0] row_trigram_count;
  logic set_overflow;
  logic last_of_input;
  modport source (output valid, output row_number, output trigram, output trigram_valid,
                  output row_end, output row_trigram_count, output set_overflow,
                  output last_of_input, input ready);
  modport sink (input valid, input row_number, input trigram, input trigram_valid,
                input row_end, input row_trigram_count, input set_overflow,
                input last_of_input, output ready);
endinterface

interface rtse_cfg_if;
  logic valid;
  logic ready;
  logic [0:0] index;
  logic [7:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/rtse_front.sv =====
module rtse_front
  import rtse_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       cfg_valid,
  input  logic [0:0] cfg_index,
  input  logic [7:0] cfg_data,
  output logic       op_valid,
  input  logic       op_ready,
  output op_t        op
);

  logic [7:0] delim;
  logic [7:0] term;
  logic [15:0] window;
  logic field_pending;
  logic line_nonempty;
  op_t slots [OPS_MAX];
  logic [1:0] remain;
  logic [1:0] ptr;

  op_t slots_next [OPS_MAX];
  logic [1:0] n_next;
  logic [15:0] window_next;
  logic fp_next;
  logic ln_next;

  assign in_ready = (remain == 2'd0);
  assign op_valid = (remain != 2'd0);
  assign op = slots[ptr];

  // split one byte into its queue ops
  always_comb begin
    for (int i = 0; i < OPS_MAX; i++) begin
      slots_next[i] = '{kind: OP_OFFER, tri_val: '0, last: 1'b0};
    end
    n_next = 2'd0;
    window_next = window;
    fp_next = field_pending;
    ln_next = line_nonempty;
    priority if (in_byte == term) begin
      if (field_pending) begin
        slots_next[0].tri_val = {window, SPACE_BYTE};
        slots_next[1].tri_val = {window[7:0], SPACE_PAIR};
        slots_next[2].kind = line_nonempty ? OP_ROWEND : OP_CLEAR;
        slots_next[2].last = 1'b1;
        n_next = 2'd3;
      end else begin
        slots_next[0].kind = line_nonempty ? OP_ROWEND : OP_CLEAR;
        slots_next[0].last = 1'b1;
        n_next = 2'd1;
      end
      window_next = SPACE_PAIR;
      fp_next = 1'b0;
      ln_next = 1'b0;
    end else if (in_byte == delim) begin
      slots_next[0].tri_val = {window, SPACE_BYTE};
      slots_next[1].tri_val = {window[7:0], SPACE_PAIR};
      slots_next[1].last = 1'b1;
      n_next = 2'd2;
      window_next = SPACE_PAIR;
      fp_next = 1'b0;
      ln_next = 1'b1;
    end else begin
      slots_next[0].tri_val = {window, in_byte};
      slots_next[0].last = 1'b1;
      n_next = 2'd1;
      window_next = {window[7:0], in_byte};
      fp_next = 1'b1;
      ln_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delim <= DELIM_RST;
      term <= TERM_RST;
      window <= SPACE_PAIR;
      field_pending <= 1'b0;
      line_nonempty <= 1'b0;
      remain <= 2'd0;
      ptr <= 2'd0;
    end else begin
      if (cfg_valid) begin
        unique case (reg_idx_t'(cfg_index))
          REG_DELIM: delim <= cfg_data;
          REG_TERM:  term <= cfg_data;
          default:   ;
        endcase
      end
      if (in_valid && in_ready) begin
        slots <= slots_next;
        remain <= n_next;
        ptr <= 2'd0;
        window <= window_next;
        field_pending <= fp_next;
        line_nonempty <= ln_next;
      end else if (op_valid && op_ready) begin
        remain <= remain - 2'd1;
        ptr <= ptr + 2'd1;
      end
    end
  end

endmodule

// ===== rtl/core/rtse_opq.sv =====
module rtse_opq
  import rtse_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic push_ready,
  input  op_t  push_op,
  output logic pop_valid,
  input  logic pop,
  output op_t  pop_op
);

  op_t mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] fill;

  assign push_ready = (fill != 3'd4);
  assign pop_valid = (fill != 3'd0);
  assign pop_op = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && push_ready) begin
      mem[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      fill <= 3'd0;
    end else begin
      if (push && push_ready) wr_ptr <= wr_ptr + 2'd1;
      if (pop && pop_valid) rd_ptr <= rd_ptr + 2'd1;
      fill <= fill + 3'((push && push_ready) ? 1 : 0) - 3'((pop && pop_valid) ? 1 : 0);
    end
  end

endmodule

// ===== rtl/core/rtse_back.sv =====
module rtse_back
  import rtse_pkg::*;
#(
  parameter int unsigned SET_DEPTH = SET_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic op_valid,
  output logic op_pop,
  input  op_t  op,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  localparam int unsigned CW = $clog2(SET_DEPTH + 1);
  localparam int unsigned AW = $clog2(SET_DEPTH);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOOK  = 5'b00010,
    S_CMP   = 5'b00100,
    S_DEC   = 5'b01000,
    S_FLUSH = 5'b10000
  } state_t;

  state_t state;
  logic [23:0] set_mem [SET_DEPTH];
  logic [23:0] rd_data;
  logic [23:0] cur_tri;
  logic cur_last;
  logic [CW-1:0] idx;
  logic [CW-1:0] count;
  logic ovf;
  logic [31:0] row_ctr;
  logic hold_v;
  res_t hold;
  logic out_free;
  logic can_make;
  logic set_full;
  logic wr_en;
  logic emit;

  assign out_free = !out_valid || out_ready;
  assign can_make = !hold_v || out_free;
  assign set_full = (count == CW'(SET_DEPTH));
  assign op_pop = (state == S_IDLE) && op_valid && can_make;
  assign wr_en = (state == S_DEC) && !set_full && can_make;
  // staged result moves to the output register this cycle
  assign emit = (op_pop && (op.kind == OP_ROWEND) && hold_v) ||
                (wr_en && hold_v) ||
                ((state == S_FLUSH) && out_free);

  always_ff @(posedge clk) begin
    if (wr_en) set_mem[count[AW-1:0]] <= cur_tri;
    if (state == S_LOOK) rd_data <= set_mem[idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      ovf <= 1'b0;
      row_ctr <= 32'd1;
      hold_v <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= emit || (out_valid && !out_ready);
      unique case (state)
        S_IDLE: begin
          if (op_pop) begin
            cur_tri <= op.tri_val;
            cur_last <= op.last;
            idx <= '0;
            unique case (op.kind)
              OP_OFFER: state <= (count == '0) ? S_DEC : S_LOOK;
              OP_ROWEND: begin
                if (hold_v) begin
                  out_res <= hold;
                end
                hold <= '{row_number: row_ctr, trigram: '0, trigram_valid: 1'b0,
                          row_end: 1'b1, row_trigram_count: 9'(count),
                          set_overflow: ovf, last_of_input: 1'b0};
                hold_v <= 1'b1;
                count <= '0;
                ovf <= 1'b0;
                if (row_ctr != '1) row_ctr <= row_ctr + 32'd1;
                state <= op.last ? S_FLUSH : S_IDLE;
              end
              OP_CLEAR: begin
                count <= '0;
                ovf <= 1'b0;
                state <= (op.last && hold_v) ? S_FLUSH : S_IDLE;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_LOOK: state <= S_CMP;
        S_CMP: begin
          if (rd_data == cur_tri) begin
            state <= (cur_last && hold_v) ? S_FLUSH : S_IDLE;
          end else if (idx + CW'(1) == count) begin
            state <= S_DEC;
          end else begin
            idx <= idx + CW'(1);
            state <= S_LOOK;
          end
        end
        S_DEC: begin
          if (set_full) begin
            ovf <= 1'b1;
            state <= (cur_last && hold_v) ? S_FLUSH : S_IDLE;
          end else if (can_make) begin
            if (hold_v) begin
              out_res <= hold;
            end
            hold <= '{row_number: row_ctr, trigram: cur_tri, trigram_valid: 1'b1,
                      row_end: 1'b0, row_trigram_count: 9'd0,
                      set_overflow: 1'b0, last_of_input: 1'b0};
            hold_v <= 1'b1;
            count <= count + CW'(1);
            state <= cur_last ? S_FLUSH : S_IDLE;
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            // last_of_input is the lowest bit of the result
            out_res <= {hold[$bits(res_t)-1:1], 1'b1};
            hold_v <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/row_trigram_set_extractor_top.sv =====
// Flow: a byte is split into 1 to 3 ops; an offer scans the row set one stored entry
// at a time (read in S_LOOK, compared in S_CMP) through the set memory read port.
// The back takes a new op only from S_IDLE, once it is through with the last one, and
// the front takes a new byte only once all ops of the last byte are passed on.
// Reset: synchronous, active high; clears control state, registers go to 124 and 10.
module row_trigram_set_extractor_top
  import rtse_pkg::*;
#(
  parameter int unsigned SET_DEPTH = SET_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  rtse_byte_if.sink byte_in,
  rtse_res_if.source res_out,
  rtse_cfg_if.sink cfg
);

  // front: classifies each byte into offer / row-end / clear ops
  logic f_valid;
  logic f_ready;
  op_t  f_op;
  // back side of the op queue
  logic q_valid;
  logic q_pop;
  op_t  q_op;
  res_t res;

  // config writes must land only while idle; the block does not enforce this and always accepts them
  assign cfg.ready = 1'b1;

  rtse_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (byte_in.valid),
    .in_ready  (byte_in.ready),
    .in_byte   (byte_in.data_byte),
    .cfg_valid (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .op_valid  (f_valid),
    .op_ready  (f_ready),
    .op        (f_op)
  );

  // short queue lets front keep taking bytes while the back scans the set
  rtse_opq u_opq (
    .clk        (clk),
    .rst        (rst),
    .push       (f_valid),
    .push_ready (f_ready),
    .push_op    (f_op),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_op     (q_op)
  );

  // back: set lookup/insert, row bookkeeping, result staging
  rtse_back #(.SET_DEPTH(SET_DEPTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (q_valid),
    .op_pop    (q_pop),
    .op        (q_op),
    .out_valid (res_out.valid),
    .out_ready (res_out.ready),
    .out_res   (res)
  );

  assign res_out.row_number = res.row_number;
  assign res_out.trigram = res.trigram;
  assign res_out.trigram_valid = res.trigram_valid;
  assign res_out.row_end = res.row_end;
  assign res_out.row_trigram_count = res.row_trigram_count;
  assign res_out.set_overflow = res.set_overflow;
  assign res_out.last_of_input = res.last_of_input;

endmodule
